@@ sv/bmpd_pkg.sv @@
// Shared types and constants of the 24-bit BMP stream decoder.
package bmpd_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam logic [31:0] HEADER_LEN = 32'd30;
  localparam logic [7:0]  SIG_B      = 8'h42;
  localparam logic [7:0]  SIG_M      = 8'h4d;
  localparam logic [15:0] DEPTH_24   = 16'd24;

  localparam logic [4:0] POS_SIG_B     = 5'd0;
  localparam logic [4:0] POS_SIG_M     = 5'd1;
  localparam logic [4:0] POS_SIZE_LO   = 5'd2;
  localparam logic [4:0] POS_SIZE_HI   = 5'd5;
  localparam logic [4:0] POS_OFFSET_LO = 5'd10;
  localparam logic [4:0] POS_OFFSET_HI = 5'd13;
  localparam logic [4:0] POS_WIDTH_LO  = 5'd18;
  localparam logic [4:0] POS_WIDTH_HI  = 5'd21;
  localparam logic [4:0] POS_HEIGHT_LO = 5'd22;
  localparam logic [4:0] POS_HEIGHT_HI = 5'd25;
  localparam logic [4:0] POS_DEPTH_LO  = 5'd28;
  localparam logic [4:0] POS_DEPTH_HI  = 5'd29;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_SIG       = 3'd1,
    ST_BAD_DEPTH     = 3'd2,
    ST_BAD_GEOM      = 3'd3,
    ST_SIZE_MISMATCH = 3'd4,
    ST_TRUNCATED     = 3'd5
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    status_e     status_code;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [31:0] pixel_data_offset;
    logic [31:0] declared_size;
    logic        final_res;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

@@ sv/bmpd_core.sv @@
// Header capture, pixel assembly and status generation, one byte a cycle while accept_i is high.
module bmpd_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_file_i,
  output bmpd_pkg::push_t push_o
);
  import bmpd_pkg::*;

  logic [31:0] pos_q, pos_d;
  logic [31:0] size_q, size_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [15:0] depth_q, depth_d;
  status_e     error_q, error_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  blue_q, blue_d;
  logic [7:0]  green_q, green_d;
  logic [11:0] col_q, col_d;
  logic [12:0] rows_q, rows_d;
  logic [13:0] rbc_q, rbc_d;

  logic [14:0] data_len;
  logic [14:0] row_len;
  logic [14:0] rbc_inc;
  logic [32:0] count;
  logic        pix_valid;
  result_t     pix_res;
  result_t     stat_res;
  status_e     st;

  always_comb begin
    pos_d    = pos_q;
    size_d   = size_q;
    offset_d = offset_q;
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    error_d  = error_q;
    phase_d  = phase_q;
    blue_d   = blue_q;
    green_d  = green_q;
    col_d    = col_q;
    rows_d   = rows_q;
    rbc_d    = rbc_q;
    pix_valid = 1'b0;
    pix_res   = '0;
    stat_res  = '0;
    st        = ST_OK;
    push_o    = '0;

    data_len = {2'b00, width_q[12:0]} + {1'b0, width_q[12:0], 1'b0};
    row_len  = (data_len + 15'd3) & ~15'd3;
    rbc_inc  = {1'b0, rbc_q} + 15'd1;
    count    = {1'b0, pos_q} + 33'd1;

    if (pos_q < HEADER_LEN) begin
      unique case (pos_q[4:0]) inside
        POS_SIG_B: begin
          if (data_byte_i != SIG_B && error_q == ST_OK) error_d = ST_BAD_SIG;
        end
        POS_SIG_M: begin
          if (data_byte_i != SIG_M && error_q == ST_OK) error_d = ST_BAD_SIG;
        end
        [POS_SIZE_LO:POS_SIZE_HI]: begin
          size_d[{pos_q[1:0] - 2'd2, 3'b000} +: 8] = data_byte_i;
        end
        [POS_OFFSET_LO:POS_OFFSET_HI]: begin
          offset_d[{pos_q[1:0] - 2'd2, 3'b000} +: 8] = data_byte_i;
        end
        [POS_WIDTH_LO:POS_WIDTH_HI]: begin
          width_d[{pos_q[1:0] - 2'd2, 3'b000} +: 8] = data_byte_i;
        end
        [POS_HEIGHT_LO:POS_HEIGHT_HI]: begin
          height_d[{pos_q[1:0] - 2'd2, 3'b000} +: 8] = data_byte_i;
        end
        [POS_DEPTH_LO:POS_DEPTH_HI]: begin
          depth_d[{pos_q[0], 3'b000} +: 8] = data_byte_i;
        end
        default: begin
        end
      endcase
      if (pos_q[4:0] == POS_DEPTH_HI && error_q == ST_OK) begin
        if (depth_d != DEPTH_24) begin
          error_d = ST_BAD_DEPTH;
        end else if (width_q == 32'd0 || width_q > 32'(MAX_WIDTH) ||
                     height_q == 32'd0 || height_q > 32'(MAX_HEIGHT) ||
                     offset_q < HEADER_LEN) begin
          error_d = ST_BAD_GEOM;
        end
      end
    end else if (error_q == ST_OK && pos_q >= offset_q &&
                 {19'd0, rows_q} < height_q) begin
      if ({1'b0, rbc_q} < data_len) begin
        case (phase_q)
          2'd0: begin
            blue_d  = data_byte_i;
            phase_d = 2'd1;
          end
          2'd1: begin
            green_d = data_byte_i;
            phase_d = 2'd2;
          end
          default: begin
            pix_valid         = 1'b1;
            pix_res.blue      = blue_q;
            pix_res.green     = green_q;
            pix_res.red       = data_byte_i;
            pix_res.pixel_row = height_q[11:0] - 12'd1 - rows_q[11:0];
            pix_res.pixel_col = col_q;
            pix_res.final_res = ~end_of_file_i;
            phase_d = 2'd0;
            col_d   = col_q + 12'd1;
          end
        endcase
      end
      if (rbc_inc >= row_len) begin
        rbc_d   = '0;
        col_d   = '0;
        phase_d = 2'd0;
        rows_d  = rows_q + 13'd1;
      end else begin
        rbc_d = rbc_inc[13:0];
      end
    end

    if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 32'd1;

    if (error_d != ST_OK) st = error_d;
    else if (pos_q < HEADER_LEN - 32'd1) st = ST_TRUNCATED;
    else if (count != {1'b0, size_d}) st = ST_SIZE_MISMATCH;
    else if ({19'd0, rows_d} < height_d) st = ST_TRUNCATED;
    else st = ST_OK;

    stat_res.kind              = 1'b1;
    stat_res.status_code       = st;
    stat_res.image_width       = (|width_d[31:13]) ? 13'h1FFF : width_d[12:0];
    stat_res.image_height      = (|height_d[31:13]) ? 13'h1FFF : height_d[12:0];
    stat_res.pixel_data_offset = offset_d;
    stat_res.declared_size     = size_d;
    stat_res.final_res         = 1'b1;

    if (accept_i) begin
      if (pix_valid && end_of_file_i) begin
        push_o.n      = 2'd2;
        push_o.first  = pix_res;
        push_o.second = stat_res;
      end else if (pix_valid) begin
        push_o.n     = 2'd1;
        push_o.first = pix_res;
      end else if (end_of_file_i) begin
        push_o.n     = 2'd1;
        push_o.first = stat_res;
      end
    end

    if (end_of_file_i) begin
      pos_d    = '0;
      size_d   = '0;
      offset_d = '0;
      width_d  = '0;
      height_d = '0;
      depth_d  = '0;
      error_d  = ST_OK;
      phase_d  = '0;
      blue_d   = '0;
      green_d  = '0;
      col_d    = '0;
      rows_d   = '0;
      rbc_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      size_q   <= '0;
      offset_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      depth_q  <= '0;
      error_q  <= ST_OK;
      phase_q  <= '0;
      blue_q   <= '0;
      green_q  <= '0;
      col_q    <= '0;
      rows_q   <= '0;
      rbc_q    <= '0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      size_q   <= size_d;
      offset_q <= offset_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      error_q  <= error_d;
      phase_q  <= phase_d;
      blue_q   <= blue_d;
      green_q  <= green_d;
      col_q    <= col_d;
      rows_q   <= rows_d;
      rbc_q    <= rbc_d;
    end
  end

endmodule

@@ sv/bmpd_queue.sv @@
// Result queue that takes up to two results a cycle and hands out one while out_ready_i is high.
module bmpd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmpd_pkg::push_t   push_i,
  output logic              can_take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bmpd_pkg::result_t out_res_o
);
  import bmpd_pkg::*;

  result_t            mem_q [QDEPTH];
  logic [QPTRW-1:0]   wr_q, wr_d;
  logic [QPTRW-1:0]   rd_q, rd_d;
  logic [QCNTW-1:0]   cnt_q, cnt_d;
  logic               pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];
  assign can_take_o  = (cnt_q <= QCNTW'(QDEPTH - 2));
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = wr_q + QPTRW'(push_i.n);
    rd_d  = pop ? rd_q + QPTRW'(1) : rd_q;
    cnt_d = cnt_q + QCNTW'(push_i.n) - QCNTW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.n == 2'd2) mem_q[wr_q + QPTRW'(1)] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ sv/bmp24_stream_decoder.sv @@
// Top level of the 24-bit BMP stream decoder.
// The decoder takes one file byte per transaction and one transaction per clock
// cycle. Every byte is processed by the decoder core, which writes its results
// into a four-entry result queue; the queue drains one result per cycle while
// the result side is ready. A byte causes at most two results: a pixel (once
// its red byte arrives) and, on the byte flagged with tlast, a status result
// after it. s_axis_tready drops while the queue holds three or more results.
// With the result side ready the queue never holds more than two, so a byte is
// taken in every cycle, the final byte that also completes a pixel included;
// input stalls come only from result-side backpressure. The header is checked
// on its 30th byte; after the final byte all state clears for the next file.
module bmp24_stream_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  // Fields from bit 0: data_byte[7:0].
  input  logic [7:0]     s_axis_tdata_i,
  input  logic           s_axis_tlast_i,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  // Fields from bit 0: blue[7:0], green[15:8], red[23:16], pixel_row[35:24],
  // pixel_col[47:36], status_code[50:48], image_width[63:51],
  // image_height[76:64], pixel_data_offset[108:77], declared_size[140:109],
  // zero fill[143:141].
  output logic [143:0]   m_axis_tdata_o,
  // Fields from bit 0: kind[0].
  output logic [0:0]     m_axis_tuser_o,
  output logic           m_axis_tlast_o
);
  import bmpd_pkg::*;

  push_t   push;
  result_t res;
  logic    accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  bmpd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (s_axis_tdata_i),
    .end_of_file_i (s_axis_tlast_i),
    .push_o        (push)
  );

  bmpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .can_take_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = {3'b000, res.declared_size, res.pixel_data_offset,
                           res.image_height, res.image_width, res.status_code,
                           res.pixel_col, res.pixel_row, res.red, res.green,
                           res.blue};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.final_res;

endmodule
